FILE: rtl/core/porq_pkg.sv
package porq_pkg;

    localparam int DEF_QUEUE_DEPTH   = 64;
    localparam int DEF_FRAME_MODULUS = 1024;
    localparam int FRAME_W           = 10;
    localparam int REG_W             = 11;
    localparam int WORD_W            = 32;
    localparam int KIND_W            = 3;
    localparam logic [WORD_W-1:0] PAGING_TYPE = 32'd100;

    localparam logic [REG_W-1:0] PAGING_CYCLE_RST = 11'd64;
    localparam logic [REG_W-1:0] MIB_PERIOD_RST   = 11'd8;

    // register indexes
    localparam logic [0:0] REG_PAGING_CYCLE = 1'b0;
    localparam logic [0:0] REG_MIB_PERIOD   = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DROP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_IGNORE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MIB     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd4;

    // command from front end to back end
    typedef struct packed {
        logic              is_req;
        logic [WORD_W-1:0] msg_kind;
        logic [WORD_W-1:0] ue_ident;
        logic [WORD_W-1:0] area_code;
        logic [WORD_W-1:0] core_domain;
    } cmd_t;

    // one result beat
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               mib_now;
        logic [FRAME_W-1:0] frame_now;
        logic [FRAME_W-1:0] frame_target;
        logic [WORD_W-1:0]  out_kind_code;
        logic [WORD_W-1:0]  out_ue;
        logic [WORD_W-1:0]  out_area;
        logic [WORD_W-1:0]  out_domain;
        logic               last;
    } res_t;

    function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] r;
        r = v;
        if (v == '0)
            r = 11'd1;
        else if (v > 11'd1024)
            r = 11'd1024;
        return r;
    endfunction

endpackage

FILE: rtl/core/porq_cmd_fifo.sv
module porq_cmd_fifo
    import porq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    // two-entry queue between front and back
    cmd_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
            mem_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
                wptr_reg <= ~wptr_reg;
            if (rd_en && !empty)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(wr_en && !full) - 2'(rd_en && !empty);
        end
    end

endmodule

FILE: rtl/core/porq_engine.sv
module porq_engine
    import porq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int FRAME_MODULUS = DEF_FRAME_MODULUS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [REG_W-1:0] paging_cycle,
    input  logic [REG_W-1:0] mib_period,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_take,
    output logic             res_valid,
    output res_t             res,
    input  logic             res_take,
    output logic             busy
);

    localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = $clog2(FRAME_W + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FIND = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_TAIL = 3'd5;

    // slot stores
    logic [FRAME_W-1:0] frame_mem [QUEUE_DEPTH];
    logic [WORD_W-1:0]  kind_mem  [QUEUE_DEPTH];
    logic [WORD_W-1:0]  ue_mem    [QUEUE_DEPTH];
    logic [WORD_W-1:0]  area_mem  [QUEUE_DEPTH];
    logic [WORD_W-1:0]  dom_mem   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] busy_reg;

    logic [2:0]         st_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] phase_reg;
    logic [CW-1:0]      idx_reg;
    logic               mib_reg;
    logic               any_reg;
    cmd_t               cur_reg;
    logic [SW-1:0]      slot_reg;
    // occasion: remainder of frame by cycle, one bit a cycle
    logic [REG_W:0]     acc_reg;
    logic [REG_W-1:0]   cyc_reg;
    logic [DW-1:0]      div_cnt_reg;

    // registered slot read during the walk
    logic               rd_v_reg;
    logic               rd_busy_reg;
    logic [SW-1:0]      rd_slot_reg;
    logic [FRAME_W-1:0] rd_frame_reg;
    logic [WORD_W-1:0]  rd_kind_reg, rd_ue_reg, rd_area_reg, rd_dom_reg;

    // release held back until the next one or the end of the walk settles last
    logic hold_v_reg;
    res_t hold_reg;

    // output register
    logic out_v_reg;
    res_t out_reg;
    logic out_load;
    res_t out_next;

    logic [SW-1:0] idx_s;
    assign idx_s = idx_reg[SW-1:0];

    logic scan_hit;
    assign scan_hit = rd_v_reg && rd_busy_reg && (rd_frame_reg == frame_reg);

    logic out_free;
    assign out_free = !out_v_reg || res_take;

    assign res_valid = out_v_reg;
    assign res       = out_reg;
    assign cmd_take  = (st_reg == ST_IDLE) && cmd_valid;
    assign busy      = (st_reg != ST_IDLE) || out_v_reg;

    logic [FRAME_W:0] frame_inc;
    assign frame_inc = {1'b0, frame_reg} + 1'b1;
    logic [REG_W-1:0] mib_cl;
    assign mib_cl = clamp_reg(mib_period);
    logic [REG_W-1:0] phase_inc;
    assign phase_inc = {1'b0, phase_reg} + 1'b1;

    // restoring remainder step and the occasion it gives
    logic [DW-1:0]  div_bit;
    logic [REG_W:0] rem_shift, rem_sub, occ_sum;
    logic [FRAME_W-1:0] occ_target;
    assign div_bit    = div_cnt_reg - DW'(1);
    assign rem_shift  = {acc_reg[REG_W-1:0], frame_reg[div_bit]};
    assign rem_sub    = (rem_shift >= {1'b0, cyc_reg}) ? rem_shift - {1'b0, cyc_reg}
                        : rem_shift;
    assign occ_sum    = (acc_reg == '0) ? {2'b0, frame_reg}
                        : {2'b0, frame_reg} + {1'b0, cyc_reg} - acc_reg;
    assign occ_target = (occ_sum >= (REG_W+1)'(FRAME_MODULUS)) ? '0
                        : occ_sum[FRAME_W-1:0];

    res_t rel_beat;
    assign rel_beat = '{KIND_RELEASE, mib_reg && !any_reg, frame_reg, rd_frame_reg,
                        rd_kind_reg, rd_ue_reg, rd_area_reg, rd_dom_reg, 1'b0};

    // store writes and reads
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_DIV && div_cnt_reg == '0)
        begin
            frame_mem[slot_reg] <= occ_target;
            kind_mem[slot_reg]  <= cur_reg.msg_kind;
            ue_mem[slot_reg]    <= cur_reg.ue_ident;
            area_mem[slot_reg]  <= cur_reg.area_code;
            dom_mem[slot_reg]   <= cur_reg.core_domain;
        end
        if (st_reg == ST_SCAN && !scan_hit && idx_reg < CW'(QUEUE_DEPTH))
        begin
            rd_slot_reg  <= idx_s;
            rd_frame_reg <= frame_mem[idx_s];
            rd_kind_reg  <= kind_mem[idx_s];
            rd_ue_reg    <= ue_mem[idx_s];
            rd_area_reg  <= area_mem[idx_s];
            rd_dom_reg   <= dom_mem[idx_s];
        end
    end

    // next output beat
    always_comb
    begin
        out_load = 1'b0;
        out_next = out_reg;
        case (st_reg)
            ST_FIND:
            begin
                if (cur_reg.msg_kind != PAGING_TYPE)
                begin
                    out_load = out_free;
                    out_next = '{KIND_IGNORE, 1'b0, frame_reg, '0, '0, '0, '0, '0, 1'b1};
                end
                else if (idx_reg == CW'(QUEUE_DEPTH))
                begin
                    out_load = out_free;
                    out_next = '{KIND_DROP, 1'b0, frame_reg, '0, '0,
                                 cur_reg.ue_ident, '0, '0, 1'b1};
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    out_load = out_free;
                    out_next = '{KIND_ACCEPT, 1'b0, frame_reg, occ_target, '0,
                                 cur_reg.ue_ident, '0, '0, 1'b1};
                end
            end
            ST_RD:
            begin
                if (hold_v_reg)
                begin
                    out_load = out_free;
                    out_next = hold_reg;
                end
            end
            ST_TAIL:
            begin
                if (hold_v_reg)
                begin
                    out_load      = out_free;
                    out_next      = hold_reg;
                    out_next.last = 1'b1;
                end
                else if (mib_reg)
                begin
                    out_load = out_free;
                    out_next = '{KIND_MIB, 1'b1, frame_reg, '0, '0, '0, '0, '0, 1'b1};
                end
            end
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            frame_reg   <= '0;
            phase_reg   <= '0;
            busy_reg    <= '0;
            out_v_reg   <= 1'b0;
            idx_reg     <= '0;
            mib_reg     <= 1'b0;
            any_reg     <= 1'b0;
            slot_reg    <= '0;
            acc_reg     <= '0;
            cyc_reg     <= '0;
            div_cnt_reg <= '0;
            cur_reg     <= '0;
            out_reg     <= '0;
            hold_v_reg  <= 1'b0;
            hold_reg    <= '0;
            rd_v_reg    <= 1'b0;
            rd_busy_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_load || (out_v_reg && !res_take);
            if (out_load)
                out_reg <= out_next;
            case (st_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg  <= cmd;
                        idx_reg  <= '0;
                        rd_v_reg <= 1'b0;
                        if (cmd.is_req)
                            st_reg <= ST_FIND;
                        else
                        begin
                            frame_reg <= (frame_inc >= (FRAME_W+1)'(FRAME_MODULUS)) ? '0
                                         : frame_inc[FRAME_W-1:0];
                            if (phase_inc >= mib_cl)
                            begin
                                mib_reg   <= 1'b1;
                                phase_reg <= '0;
                            end
                            else
                            begin
                                mib_reg   <= 1'b0;
                                phase_reg <= phase_inc[FRAME_W-1:0];
                            end
                            any_reg <= 1'b0;
                            st_reg  <= ST_SCAN;
                        end
                    end
                end
                // look for the lowest free slot, one a cycle
                ST_FIND:
                begin
                    if (cur_reg.msg_kind != PAGING_TYPE || idx_reg == CW'(QUEUE_DEPTH))
                    begin
                        if (out_load)
                            st_reg <= ST_IDLE;
                    end
                    else if (!busy_reg[idx_s])
                    begin
                        slot_reg    <= idx_s;
                        cyc_reg     <= clamp_reg(paging_cycle);
                        acc_reg     <= '0;
                        div_cnt_reg <= DW'(FRAME_W);
                        st_reg      <= ST_DIV;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                // frame mod cycle, one frame bit a cycle, then the beat
                ST_DIV:
                begin
                    if (div_cnt_reg != '0)
                    begin
                        acc_reg     <= rem_sub;
                        div_cnt_reg <= div_bit;
                    end
                    else if (out_load)
                    begin
                        busy_reg[slot_reg] <= 1'b1;
                        st_reg             <= ST_IDLE;
                    end
                end
                // read one slot a cycle, pausing at a match; check the one read the cycle before
                ST_SCAN:
                begin
                    if (scan_hit)
                        st_reg <= ST_RD;
                    else if (idx_reg == CW'(QUEUE_DEPTH))
                        st_reg <= ST_TAIL;
                    else
                    begin
                        rd_busy_reg <= busy_reg[idx_s];
                        rd_v_reg    <= 1'b1;
                        idx_reg     <= idx_reg + 1'b1;
                    end
                end
                // hold this release; the one held before goes out
                ST_RD:
                begin
                    if (!hold_v_reg || out_load)
                    begin
                        hold_reg              <= rel_beat;
                        hold_v_reg            <= 1'b1;
                        busy_reg[rd_slot_reg] <= 1'b0;
                        any_reg               <= 1'b1;
                        rd_v_reg              <= 1'b0;
                        st_reg                <= ST_SCAN;
                    end
                end
                // final release carries last, or a lone broadcast beat
                ST_TAIL:
                begin
                    if (!hold_v_reg && !mib_reg)
                        st_reg <= ST_IDLE;
                    else if (out_load)
                    begin
                        hold_v_reg <= 1'b0;
                        st_reg     <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/paging_occasion_release_queue.sv
// Paging occasion release queue.
// Input side: a queue write port. An item (a frame tick or a paging request)
// is taken at a clock edge with push high and full low. Two items fit in the
// front queue; it fills only when items arrive while the back end is busy.
// Result side: a queue read port. While empty is low the oldest result beat is
// on the result ports; pop high at a clock edge takes it.
// Configuration: cfg_we, cfg_index, cfg_data write paging_cycle (0) and
// mib_period (1) straight away; write only while the block is idle.
// Request path: a request gives its single beat after a search of up to
// QUEUE_DEPTH slots for a free one and a division for frame mod paging_cycle.
// Tick path: a tick walks all QUEUE_DEPTH slots, one per cycle, pausing at
// each release found. Items are handled one at a time by the back end.
// Each release is held one beat back so that the final one carries last.
// Reset clears the frame counter, broadcast phase and all slot busy bits.
// A stalled receiver halts the back end; the front queue fills, then full.
module paging_occasion_release_queue
    import porq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int FRAME_MODULUS = DEF_FRAME_MODULUS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [REG_W-1:0]   cfg_data,
    input  logic               push,
    output logic               full,
    input  logic               req_type,
    input  logic [WORD_W-1:0]  msg_kind,
    input  logic [WORD_W-1:0]  ue_ident,
    input  logic [WORD_W-1:0]  area_code,
    input  logic [WORD_W-1:0]  core_domain,
    output logic               empty,
    input  logic               pop,
    output logic [KIND_W-1:0]  kind,
    output logic               mib_now,
    output logic [FRAME_W-1:0] frame_now,
    output logic [FRAME_W-1:0] frame_target,
    output logic [WORD_W-1:0]  out_kind_code,
    output logic [WORD_W-1:0]  out_ue,
    output logic [WORD_W-1:0]  out_area,
    output logic [WORD_W-1:0]  out_domain,
    output logic               last
);

    logic [REG_W-1:0] paging_cycle_reg, mib_period_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paging_cycle_reg <= PAGING_CYCLE_RST;
            mib_period_reg   <= MIB_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PAGING_CYCLE)
                paging_cycle_reg <= cfg_data;
            else
                mib_period_reg <= cfg_data;
        end
    end

    cmd_t in_cmd, q_cmd;
    logic q_empty, q_take;
    assign in_cmd = '{req_type, msg_kind, ue_ident, area_code, core_domain};

    porq_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_cmd),
        .full    (full),
        .rd_en   (q_take),
        .rd_data (q_cmd),
        .empty   (q_empty)
    );

    res_t r;
    logic r_valid, eng_busy;

    porq_engine #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .FRAME_MODULUS (FRAME_MODULUS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .paging_cycle (paging_cycle_reg),
        .mib_period   (mib_period_reg),
        .cmd_valid    (!q_empty),
        .cmd          (q_cmd),
        .cmd_take     (q_take),
        .res_valid    (r_valid),
        .res          (r),
        .res_take     (pop),
        .busy         (eng_busy)
    );

    assign empty         = !r_valid;
    assign kind          = r.kind;
    assign mib_now       = r.mib_now;
    assign frame_now     = r.frame_now;
    assign frame_target  = r.frame_target;
    assign out_kind_code = r.out_kind_code;
    assign out_ue        = r.out_ue;
    assign out_area      = r.out_area;
    assign out_domain    = r.out_domain;
    assign last          = r.last;

    // a result only while the back end has work or holds one
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> eng_busy) else $error("result without work");
    // request beats are always final
    a_req_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == KIND_ACCEPT || kind == KIND_DROP || kind == KIND_IGNORE))
        |-> last) else $error("request beat not last");
    // broadcast-only beat always flags the broadcast and is final
    a_mib: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_MIB) |-> (mib_now && last))
        else $error("broadcast beat malformed");

endmodule
